// ===== rtl/plru_pkg.sv =====
`default_nettype none

package plru_pkg;

  localparam int PEER_W = 32;
  localparam int SOCK_W = 16;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic [1:0] {
    STAT_PENDING   = 2'd0,
    STAT_COMPLETE  = 2'd1,
    STAT_DUPLICATE = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_UPDATE = 1'b1
  } state_t;

  // Source of a cell's next contents.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_NEW  = 2'd1,
    CELL_PREV = 2'd2,
    CELL_NEXT = 2'd3
  } cell_sel_t;

  typedef struct packed {
    cell_sel_t sel;
    logic      drop;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/plru_cell.sv =====
`default_nettype none

module plru_cell #(
  parameter int SOCKETS_PER_PEER = 3
) (
  input  wire                                         clk,
  input  wire                                         rst_n,
  input  wire  plru_pkg::cell_ctrl_t                  ctrl,
  input  wire  [plru_pkg::PEER_W-1:0]                 lookup_peer,
  input  wire  [plru_pkg::PEER_W-1:0]                 new_peer,
  input  wire  [$clog2(SOCKETS_PER_PEER+1)-1:0]       new_count,
  input  wire  [SOCKETS_PER_PEER*plru_pkg::SOCK_W-1:0] new_socks,
  input  wire                                         prev_valid,
  input  wire  [plru_pkg::PEER_W-1:0]                 prev_peer,
  input  wire  [$clog2(SOCKETS_PER_PEER+1)-1:0]       prev_count,
  input  wire  [SOCKETS_PER_PEER*plru_pkg::SOCK_W-1:0] prev_socks,
  input  wire                                         next_valid,
  input  wire  [plru_pkg::PEER_W-1:0]                 next_peer,
  input  wire  [$clog2(SOCKETS_PER_PEER+1)-1:0]       next_count,
  input  wire  [SOCKETS_PER_PEER*plru_pkg::SOCK_W-1:0] next_socks,
  output logic                                        valid,
  output logic [plru_pkg::PEER_W-1:0]                 peer,
  output logic [$clog2(SOCKETS_PER_PEER+1)-1:0]       count,
  output logic [SOCKETS_PER_PEER*plru_pkg::SOCK_W-1:0] socks,
  output logic                                        match
);

  localparam int CW = $clog2(SOCKETS_PER_PEER + 1);
  localparam int SW = SOCKETS_PER_PEER * plru_pkg::SOCK_W;

  logic                        valid_r;
  logic                        valid_nxt;
  logic [plru_pkg::PEER_W-1:0] peer_r;
  logic [plru_pkg::PEER_W-1:0] peer_nxt;
  logic [CW-1:0]               count_r;
  logic [CW-1:0]               count_nxt;
  logic [SW-1:0]               socks_r;
  logic [SW-1:0]               socks_nxt;
  logic                        sel_valid;

  always_comb begin
    case (ctrl.sel)
      plru_pkg::CELL_NEW: begin
        sel_valid = 1'b1;
        peer_nxt  = new_peer;
        count_nxt = new_count;
        socks_nxt = new_socks;
      end
      plru_pkg::CELL_PREV: begin
        sel_valid = prev_valid;
        peer_nxt  = prev_peer;
        count_nxt = prev_count;
        socks_nxt = prev_socks;
      end
      plru_pkg::CELL_NEXT: begin
        sel_valid = next_valid;
        peer_nxt  = next_peer;
        count_nxt = next_count;
        socks_nxt = next_socks;
      end
      default: begin
        sel_valid = valid_r;
        peer_nxt  = peer_r;
        count_nxt = count_r;
        socks_nxt = socks_r;
      end
    endcase
    valid_nxt = sel_valid & ~ctrl.drop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    peer_r  <= peer_nxt;
    count_r <= count_nxt;
    socks_r <= socks_nxt;
  end

  assign valid = valid_r;
  assign peer  = peer_r;
  assign count = count_r;
  assign socks = socks_r;
  assign match = valid_r && (peer_r == lookup_peer);

endmodule

`default_nettype wire

// ===== rtl/pending_connection_lru_table_core.sv =====
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  in_peer_id, in_socket_handle
// out_     output     out_valid/out_stall out_status, out_sock_*, out_evicted*
// cfg_     input      cfg_we             cfg_wdata (max_pending)
//
// The peer id is compared in every cell as the request is accepted, and the
// cell list is rewritten in the update state, which holds off new requests.
// A stalled result holds the update cycle until the output register frees.
// Cells are kept packed in recency order, cell 0 most recent.
// Synchronous active-low reset empties the table and sets max_pending to 16.
`default_nettype none

module pending_connection_lru_table_core #(
  parameter int MAX_ENTRIES      = 16,
  parameter int SOCKETS_PER_PEER = 3
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [plru_pkg::PEER_W-1:0]  in_peer_id,
  input  wire  [plru_pkg::SOCK_W-1:0]  in_socket_handle,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [1:0]                   out_status,
  output logic [plru_pkg::SOCK_W-1:0]  out_sock_first,
  output logic [plru_pkg::SOCK_W-1:0]  out_sock_second,
  output logic [plru_pkg::SOCK_W-1:0]  out_sock_third,
  output logic                         out_evicted,
  output logic [plru_pkg::PEER_W-1:0]  out_evicted_peer,
  input  wire                          cfg_we,
  input  wire  [plru_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int UW    = $clog2(MAX_ENTRIES + 1);
  localparam int CW    = $clog2(SOCKETS_PER_PEER + 1);
  localparam int SW    = SOCKETS_PER_PEER * plru_pkg::SOCK_W;
  localparam int LW    = (UW > plru_pkg::CFG_W) ? UW : plru_pkg::CFG_W;
  localparam int LANES = (SOCKETS_PER_PEER > 3) ? SOCKETS_PER_PEER : 3;

  plru_pkg::state_t            state_r;
  plru_pkg::state_t            state_nxt;
  logic [plru_pkg::CFG_W-1:0]  max_pending_r;
  logic [UW-1:0]               used_r;
  logic [UW-1:0]               used_nxt;
  logic [plru_pkg::PEER_W-1:0] req_peer_r;
  logic [plru_pkg::SOCK_W-1:0] req_sock_r;
  logic [MAX_ENTRIES-1:0]      hit_r;
  logic                        accept;
  logic                        fire;

  // cell chain
  logic [MAX_ENTRIES-1:0]      cell_valid;
  logic [MAX_ENTRIES-1:0]      cell_match;
  logic [plru_pkg::PEER_W-1:0] cell_peer  [MAX_ENTRIES];
  logic [CW-1:0]               cell_count [MAX_ENTRIES];
  logic [SW-1:0]               cell_socks [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]      prv_valid;
  logic [plru_pkg::PEER_W-1:0] prv_peer   [MAX_ENTRIES];
  logic [CW-1:0]               prv_count  [MAX_ENTRIES];
  logic [SW-1:0]               prv_socks  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]      nxt_valid;
  logic [plru_pkg::PEER_W-1:0] nxt_peer   [MAX_ENTRIES];
  logic [CW-1:0]               nxt_count  [MAX_ENTRIES];
  logic [SW-1:0]               nxt_socks  [MAX_ENTRIES];
  plru_pkg::cell_ctrl_t        cell_ctrl  [MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0]      is_last;
  logic [MAX_ENTRIES-1:0]      evict_here;
  logic [MAX_ENTRIES-1:0]      evict_prev;
  logic [MAX_ENTRIES-1:0]      at_or_above_hit;
  logic [MAX_ENTRIES-1:0]      at_or_below_hit;

  // update datapath
  logic                        hit_any;
  logic [CW-1:0]               hit_count;
  logic [SW-1:0]               hit_socks;
  logic [CW-1:0]               base_count;
  logic [SW-1:0]               base_socks;
  logic [CW-1:0]               new_count;
  logic [SW-1:0]               new_socks;
  logic [plru_pkg::SOCK_W-1:0] lane [LANES];
  logic [LW-1:0]               cfg_ext;
  logic [LW-1:0]               lim;
  logic                        do_evict;
  logic                        dup;
  logic                        complete;
  logic                        add;
  plru_pkg::status_t           status;
  logic [plru_pkg::PEER_W-1:0] ev_peer;

  // output register
  logic                        out_valid_r;
  plru_pkg::status_t           out_status_r;
  logic [plru_pkg::SOCK_W-1:0] out_s0_r;
  logic [plru_pkg::SOCK_W-1:0] out_s1_r;
  logic [plru_pkg::SOCK_W-1:0] out_s2_r;
  logic                        out_ev_r;
  logic [plru_pkg::PEER_W-1:0] out_ev_peer_r;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != plru_pkg::ST_IDLE);
  assign fire     = (state_r == plru_pkg::ST_UPDATE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plru_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = plru_pkg::ST_UPDATE;
        end
      end
      plru_pkg::ST_UPDATE: begin
        if (fire) begin
          state_nxt = plru_pkg::ST_IDLE;
        end
      end
      default: state_nxt = plru_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= plru_pkg::ST_IDLE;
      max_pending_r <= plru_pkg::CFG_RESET;
      used_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        max_pending_r <= cfg_wdata;
      end
      if (fire) begin
        used_r <= used_nxt;
      end
    end
  end

  // Capture the request and the match vector of the whole chain.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_peer_r <= in_peer_id;
      req_sock_r <= in_socket_handle;
      hit_r      <= cell_match;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign prv_valid[gi]  = 1'b0;
        assign prv_peer[gi]   = '0;
        assign prv_count[gi]  = '0;
        assign prv_socks[gi]  = '0;
        assign evict_prev[gi] = 1'b0;
      end else begin : g_mid_prev
        assign prv_valid[gi]  = cell_valid[gi-1];
        assign prv_peer[gi]   = cell_peer[gi-1];
        assign prv_count[gi]  = cell_count[gi-1];
        assign prv_socks[gi]  = cell_socks[gi-1];
        assign evict_prev[gi] = evict_here[gi-1];
      end
      if (gi == MAX_ENTRIES - 1) begin : g_last
        assign nxt_valid[gi] = 1'b0;
        assign nxt_peer[gi]  = '0;
        assign nxt_count[gi] = '0;
        assign nxt_socks[gi] = '0;
        assign is_last[gi]   = cell_valid[gi];
      end else begin : g_mid_next
        assign nxt_valid[gi] = cell_valid[gi+1];
        assign nxt_peer[gi]  = cell_peer[gi+1];
        assign nxt_count[gi] = cell_count[gi+1];
        assign nxt_socks[gi] = cell_socks[gi+1];
        assign is_last[gi]   = cell_valid[gi] & ~cell_valid[gi+1];
      end
      assign evict_here[gi]      = do_evict & is_last[gi];
      assign at_or_above_hit[gi] = |hit_r[MAX_ENTRIES-1:gi];
      assign at_or_below_hit[gi] = |hit_r[gi:0];

      plru_cell #(
        .SOCKETS_PER_PEER (SOCKETS_PER_PEER)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (cell_ctrl[gi]),
        .lookup_peer (in_peer_id),
        .new_peer    (req_peer_r),
        .new_count   (new_count),
        .new_socks   (new_socks),
        .prev_valid  (prv_valid[gi]),
        .prev_peer   (prv_peer[gi]),
        .prev_count  (prv_count[gi]),
        .prev_socks  (prv_socks[gi]),
        .next_valid  (nxt_valid[gi]),
        .next_peer   (nxt_peer[gi]),
        .next_count  (nxt_count[gi]),
        .next_socks  (nxt_socks[gi]),
        .valid       (cell_valid[gi]),
        .peer        (cell_peer[gi]),
        .count       (cell_count[gi]),
        .socks       (cell_socks[gi]),
        .match       (cell_match[gi])
      );
    end
  endgenerate

  always_comb begin
    hit_any   = |hit_r;
    hit_count = '0;
    hit_socks = '0;
    ev_peer   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit_r[i]) begin
        hit_count = hit_count | cell_count[i];
        hit_socks = hit_socks | cell_socks[i];
      end
      if (evict_here[i]) begin
        ev_peer = ev_peer | cell_peer[i];
      end
    end

    // Clamp the limit into 1..MAX_ENTRIES.
    cfg_ext = LW'(max_pending_r);
    if (cfg_ext == '0) begin
      lim = LW'(1);
    end else if (cfg_ext > LW'(MAX_ENTRIES)) begin
      lim = LW'(MAX_ENTRIES);
    end else begin
      lim = cfg_ext;
    end
    do_evict = !hit_any && (LW'(used_r) >= lim);

    base_count = hit_any ? hit_count : '0;
    base_socks = hit_any ? hit_socks : '0;

    dup = 1'b0;
    for (int j = 0; j < SOCKETS_PER_PEER; j++) begin
      if ((CW'(j) < base_count) &&
          (base_socks[j*plru_pkg::SOCK_W +: plru_pkg::SOCK_W] == req_sock_r)) begin
        dup = 1'b1;
      end
    end

    if (base_count >= CW'(SOCKETS_PER_PEER)) begin
      status = plru_pkg::STAT_FULL;
    end else if (dup) begin
      status = plru_pkg::STAT_DUPLICATE;
    end else if (base_count + CW'(1) == CW'(SOCKETS_PER_PEER)) begin
      status = plru_pkg::STAT_COMPLETE;
    end else begin
      status = plru_pkg::STAT_PENDING;
    end
    complete = (status == plru_pkg::STAT_COMPLETE);
    add      = complete || (status == plru_pkg::STAT_PENDING);

    new_count = add ? base_count + CW'(1) : base_count;
    new_socks = base_socks;
    for (int j = 0; j < SOCKETS_PER_PEER; j++) begin
      if (add && (CW'(j) == base_count)) begin
        new_socks[j*plru_pkg::SOCK_W +: plru_pkg::SOCK_W] = req_sock_r;
      end
    end
    for (int j = 0; j < LANES; j++) begin
      lane[j] = '0;
      if (j < SOCKETS_PER_PEER) begin
        lane[j] = new_socks[j*plru_pkg::SOCK_W +: plru_pkg::SOCK_W];
      end
    end

    used_nxt = used_r + UW'(!hit_any) - UW'(do_evict) - UW'(complete);
  end

  // Move the requested entry to the front, or close its gap when it completes.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cell_ctrl[i].sel  = plru_pkg::CELL_HOLD;
      cell_ctrl[i].drop = 1'b0;
      if (fire) begin
        if (!complete) begin
          if (i == 0) begin
            cell_ctrl[i].sel = plru_pkg::CELL_NEW;
          end else if (hit_any) begin
            cell_ctrl[i].sel = at_or_above_hit[i] ? plru_pkg::CELL_PREV : plru_pkg::CELL_HOLD;
          end else begin
            cell_ctrl[i].sel  = plru_pkg::CELL_PREV;
            cell_ctrl[i].drop = evict_prev[i];
          end
        end else if (hit_any) begin
          cell_ctrl[i].sel = at_or_below_hit[i] ? plru_pkg::CELL_NEXT : plru_pkg::CELL_HOLD;
        end else begin
          cell_ctrl[i].drop = evict_here[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r  <= status;
      out_s0_r      <= complete ? lane[0] : '0;
      out_s1_r      <= complete ? lane[1] : '0;
      out_s2_r      <= complete ? lane[2] : '0;
      out_ev_r      <= do_evict;
      out_ev_peer_r <= ev_peer;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_sock_first   = out_s0_r;
  assign out_sock_second  = out_s1_r;
  assign out_sock_third   = out_s2_r;
  assign out_evicted      = out_ev_r;
  assign out_evicted_peer = out_ev_peer_r;

`ifndef ASSERT_OFF
  a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid & (cell_valid + MAX_ENTRIES'(1))) == '0) &&
    ($countones(cell_valid) == int'(used_r)))
    else $error("cell chain not packed or occupancy mismatch");

  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plru_pkg::ST_UPDATE) |-> $onehot0(hit_r))
    else $error("peer matched in more than one cell");

  a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == plru_pkg::ST_UPDATE))
    else $error("result raised without an update cycle");
`endif

endmodule

`default_nettype wire
